FILE: hw/rtl/mfsgd_pkg.sv
// ----------------------------------------------------------------------------
// mfsgd_pkg : shared types and constants for the SGD factor update core
// Sizes, fixed-point widths, transaction structs, opcodes and FSM states.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

   localparam int unsigned USERS = 1024;
   localparam int unsigned ITEMS = 1024;
   localparam int unsigned RANK  = 16;
   localparam int unsigned FRAC  = 16;   // fraction bits of the factor format

   localparam int unsigned UDEPTH = USERS * RANK;
   localparam int unsigned IDEPTH = ITEMS * RANK;
   localparam int unsigned UA_W   = (UDEPTH > 1) ? $clog2(UDEPTH) : 1;
   localparam int unsigned IA_W   = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
   localparam int unsigned K_W    = (RANK > 1) ? $clog2(RANK) : 1;
   localparam int unsigned CNT_W  = $clog2(RANK + 1);
   localparam logic [K_W-1:0] K_LAST = K_W'(RANK - 1);

   // dot product accumulator and error
   localparam int unsigned ACC_W = 64 - FRAC + CNT_W;
   localparam int unsigned ERR_W = ACC_W + 1;
   // update datapath
   localparam int unsigned BF_W = 49;            // beta (17 signed) * factor (32)
   localparam int unsigned D_W  = 66 - FRAC;     // 2*grad - reg
   localparam int unsigned H_W  = D_W - 16;      // high part of d
   localparam int unsigned HA_W = H_W + 17;      // high part * alpha
   localparam int unsigned S_W  = HA_W + 1;      // factor + step

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;

   localparam logic [15:0] ALPHA_RESET = 16'd655;
   localparam logic [15:0] BETA_RESET  = 16'd1311;

   localparam logic CSR_ALPHA = 1'b0;
   localparam logic CSR_BETA  = 1'b1;

   localparam logic [2:0] OP_WR_USER = 3'd0;
   localparam logic [2:0] OP_WR_ITEM = 3'd1;
   localparam logic [2:0] OP_RD_USER = 3'd2;
   localparam logic [2:0] OP_RD_ITEM = 3'd3;
   localparam logic [2:0] OP_TRAIN   = 3'd4;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [9:0]         user_index;
      logic [9:0]         item_index;
      logic [3:0]         factor_index;
      logic signed [31:0] write_value;
      logic [7:0]         rating;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic signed [31:0] prediction_error;
      logic               update_skipped;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic           vld;
      logic [K_W-1:0] idx;
   } upd_tag_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACCESS,
      S_FETCH,
      S_MACWAIT,
      S_ERR,
      S_UPDATE,
      S_WBWAIT,
      S_DONE
   } state_type;

endpackage

FILE: hw/rtl/mfsgd_cell.sv
// ----------------------------------------------------------------------------
// mfsgd_cell : one factor-pair cell of the shift chain
// Holds a user/item factor pair and passes it on when the chain shifts.
// ----------------------------------------------------------------------------
module mfsgd_cell (
   input  logic               clock,
   input  logic               shift_i,
   input  logic signed [31:0] p_i,
   input  logic signed [31:0] q_i,
   output logic signed [31:0] p_o,
   output logic signed [31:0] q_o
);
   import mfsgd_pkg::*;

   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] q_ff, q_in;

   always_comb begin
      p_in = shift_i ? p_i : p_ff;
      q_in = shift_i ? q_i : q_ff;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
   end

   assign p_o = p_ff;
   assign q_o = q_ff;

endmodule

FILE: hw/rtl/mfsgd_upd.sv
// ----------------------------------------------------------------------------
// mfsgd_upd : pipelined factor update unit
// new = f + floor(alpha * (2*floor(e*g) - floor(beta*f))), clipped to 32 bits.
// ----------------------------------------------------------------------------
module mfsgd_upd (
   input  logic                     clock,
   input  logic                     reset,
   input  mfsgd_pkg::upd_tag_type   tag_i,
   input  logic signed [31:0]       f_i,
   input  logic signed [31:0]       g_i,
   input  logic signed [31:0]       err_i,
   input  logic [15:0]              alpha_i,
   input  logic [15:0]              beta_i,
   output mfsgd_pkg::upd_tag_type   tag_o,
   output logic signed [31:0]       new_o,
   output logic                     sat_o,
   output logic                     busy_o
);
   import mfsgd_pkg::*;

   upd_tag_type            tag1_ff, tag2_ff, tag3_ff;
   logic signed [63:0]     eg_ff, eg_in;
   logic signed [BF_W-1:0] bf_ff, bf_in;
   logic signed [31:0]     f1_ff, f2_ff, f3_ff;
   logic signed [D_W-1:0]  d_ff, d_in;
   logic signed [H_W-1:0]  hi;
   logic signed [HA_W-1:0] ha_ff, ha_in;
   logic [31:0]            la_ff, la_in;
   logic signed [S_W-1:0]  sum;

   // stage 1: gradient and regularisation products
   always_comb begin
      eg_in = 64'(err_i) * 64'(g_i);
      bf_in = BF_W'($signed({1'b0, beta_i})) * BF_W'(f_i);
   end

   // stage 2: difference, both terms floored
   always_comb begin
      d_in = (D_W'(eg_ff >>> FRAC) <<< 1) - D_W'(bf_ff >>> 16);
   end

   // stage 3: alpha scaling split into high and low partial products
   always_comb begin
      hi    = H_W'(d_ff >>> 16);
      ha_in = HA_W'(hi) * HA_W'($signed({1'b0, alpha_i}));
      la_in = 32'(d_ff[15:0]) * 32'(alpha_i);
   end

   // output: add and clip
   always_comb begin
      sum = S_W'(f3_ff) + S_W'(ha_ff) + S_W'($signed({1'b0, la_ff[31:16]}));
      if (sum > S_W'(S32_MAX)) begin
         new_o = S32_MAX;
         sat_o = 1'b1;
      end else if (sum < S_W'(S32_MIN)) begin
         new_o = S32_MIN;
         sat_o = 1'b1;
      end else begin
         new_o = 32'(sum);
         sat_o = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      eg_ff <= eg_in;
      bf_ff <= bf_in;
      f1_ff <= f_i;
      d_ff  <= d_in;
      f2_ff <= f1_ff;
      ha_ff <= ha_in;
      la_ff <= la_in;
      f3_ff <= f2_ff;
   end

   assign tag_o  = tag3_ff;
   assign busy_o = tag1_ff.vld | tag2_ff.vld | tag3_ff.vld;

endmodule

FILE: hw/rtl/matrix_factorization_sgd_update_core.sv
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_update_core : SGD latent-factor update engine
// Throughput: one transaction in flight; a train is bound by the single port of
//   each factor memory, RANK reads then RANK writes.
// Reset: synchronous, active high; clears control, restores alpha and beta;
//   factor memories are not cleared and hold no value until written.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_update_core (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  mfsgd_pkg::req_type req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mfsgd_pkg::rsp_type rsp_data,
   // register write port
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wr_data
);
   import mfsgd_pkg::*;

   // ---------------------------------------------------------------------
   // Control and configuration
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [15:0] alpha_ff, alpha_in;
   logic [15:0] beta_ff, beta_in;
   logic [K_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [K_W-1:0] out_cnt_ff, out_cnt_in;
   logic rdv_ff, rdv_in;           // read data of a fetch is in the data regs
   logic prod_v_ff, prod_v_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_load;

   // decoded request
   logic uok, iok, fok, skip;
   logic [UA_W-1:0] ubase;
   logic [IA_W-1:0] ibase;

   // memory ports
   logic [31:0] user_mem [UDEPTH];
   logic [31:0] item_mem [IDEPTH];
   logic u_we, u_re, i_we, i_re;
   logic [UA_W-1:0] u_addr;
   logic [IA_W-1:0] i_addr;
   logic [31:0] u_wdata, i_wdata;
   logic [31:0] u_rdata_ff, i_rdata_ff;

   // dot product
   logic signed [63:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] err_w;
   logic signed [31:0]      err_ff, err_in;
   logic                    sat_ff, sat_in;

   // cell chain and update units
   logic signed [31:0] p_link [RANK+1];
   logic signed [31:0] q_link [RANK+1];
   logic chain_shift;
   upd_tag_type upd_tag, p_tag, q_tag;
   logic signed [31:0] p_new, q_new;
   logic p_sat, q_sat, p_busy, q_busy;

   assign uok   = 32'(req_ff.user_index) < USERS;
   assign iok   = 32'(req_ff.item_index) < ITEMS;
   assign fok   = 32'(req_ff.factor_index) < RANK;
   assign skip  = (req_ff.rating == 8'd0) || !uok || !iok;
   assign ubase = UA_W'(req_ff.user_index) * UA_W'(RANK);
   assign ibase = IA_W'(req_ff.item_index) * IA_W'(RANK);

   // ---------------------------------------------------------------------
   // FSM: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_ACCESS;
         end
         S_ACCESS: begin
            if (req_ff.opcode == OP_TRAIN && !skip) state_in = S_FETCH;
            else state_in = S_DONE;
         end
         S_FETCH: begin
            if (rd_cnt_ff == K_LAST) state_in = S_MACWAIT;
         end
         S_MACWAIT: begin
            if (!rdv_ff && !prod_v_ff) state_in = S_ERR;
         end
         S_ERR: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_cnt_ff == K_LAST) state_in = S_WBWAIT;
         end
         S_WBWAIT: begin
            if (!p_busy && !q_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // FSM: outputs (memory ports, counters, handshakes)
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      u_we       = 1'b0;
      u_re       = 1'b0;
      i_we       = 1'b0;
      i_re       = 1'b0;
      u_addr     = ubase + UA_W'(req_ff.factor_index);
      i_addr     = ibase + IA_W'(req_ff.factor_index);
      u_wdata    = req_ff.write_value;
      i_wdata    = req_ff.write_value;
      rd_cnt_in  = '0;
      out_cnt_in = '0;
      rdv_in     = 1'b0;
      upd_tag    = '0;
      rsp_load   = 1'b0;
      case (state_ff)
         S_ACCESS: begin
            case (req_ff.opcode)
               OP_WR_USER: u_we = uok && fok;
               OP_WR_ITEM: i_we = iok && fok;
               OP_RD_USER: u_re = uok && fok;
               OP_RD_ITEM: i_re = iok && fok;
               default: ;
            endcase
         end
         S_FETCH: begin
            u_re      = 1'b1;
            i_re      = 1'b1;
            u_addr    = ubase + UA_W'(rd_cnt_ff);
            i_addr    = ibase + IA_W'(rd_cnt_ff);
            rdv_in    = 1'b1;
            rd_cnt_in = (rd_cnt_ff == K_LAST) ? '0 : rd_cnt_ff + 1'b1;
         end
         S_UPDATE: begin
            upd_tag.vld = 1'b1;
            upd_tag.idx = out_cnt_ff;
            out_cnt_in  = (out_cnt_ff == K_LAST) ? '0 : out_cnt_ff + 1'b1;
         end
         S_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: ;
      endcase
      // write-back of updated pairs as they leave the update pipeline
      if (p_tag.vld) begin
         u_we    = 1'b1;
         i_we    = 1'b1;
         u_addr  = ubase + UA_W'(p_tag.idx);
         i_addr  = ibase + IA_W'(p_tag.idx);
         u_wdata = p_new;
         i_wdata = q_new;
      end
   end

   // request capture and register writes
   always_comb begin
      req_in   = (req_valid && req_ready) ? req_data : req_ff;
      alpha_in = alpha_ff;
      beta_in  = beta_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = csr_wr_data;
            CSR_BETA:  beta_in  = csr_wr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Dot product: multiply, then floor and accumulate
   // ---------------------------------------------------------------------
   always_comb begin
      prod_in   = 64'($signed(u_rdata_ff)) * 64'($signed(i_rdata_ff));
      prod_v_in = rdv_ff;
      acc_in    = acc_ff;
      if (state_ff == S_ACCESS) acc_in = '0;
      else if (prod_v_ff) acc_in = acc_ff + ACC_W'(prod_ff >>> FRAC);
   end

   // error = rating - prediction, clipped; sat collects every clip
   always_comb begin
      err_w  = (ERR_W'($signed({1'b0, req_ff.rating})) <<< FRAC) - ERR_W'(acc_ff);
      err_in = err_ff;
      sat_in = sat_ff;
      if (state_ff == S_ERR) begin
         if (err_w > ERR_W'(S32_MAX)) begin
            err_in = S32_MAX;
            sat_in = 1'b1;
         end else if (err_w < ERR_W'(S32_MIN)) begin
            err_in = S32_MIN;
            sat_in = 1'b1;
         end else begin
            err_in = 32'(err_w);
            sat_in = 1'b0;
         end
      end else if (p_tag.vld) begin
         sat_in = sat_ff | p_sat | q_sat;
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_load) begin
         rsp_in = '0;
         case (req_ff.opcode)
            OP_RD_USER: if (uok && fok) rsp_in.read_value = u_rdata_ff;
            OP_RD_ITEM: if (iok && fok) rsp_in.read_value = i_rdata_ff;
            OP_TRAIN: begin
               if (skip) begin
                  rsp_in.update_skipped = 1'b1;
               end else begin
                  rsp_in.prediction_error = err_ff;
                  rsp_in.saturated        = sat_ff;
               end
            end
            default: ;
         endcase
      end
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_ff     <= ALPHA_RESET;
         beta_ff      <= BETA_RESET;
         rd_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         rdv_ff       <= 1'b0;
         prod_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         rd_cnt_ff    <= rd_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rdv_ff       <= rdv_in;
         prod_v_ff    <= prod_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      err_ff  <= err_in;
      sat_ff  <= sat_in;
      rsp_ff  <= rsp_in;
   end

   // single-port factor memories, registered read
   always_ff @(posedge clock) begin
      if (u_we) user_mem[u_addr] <= u_wdata;
      if (u_re) u_rdata_ff <= user_mem[u_addr];
   end

   always_ff @(posedge clock) begin
      if (i_we) item_mem[i_addr] <= i_wdata;
      if (i_re) i_rdata_ff <= item_mem[i_addr];
   end

   // ---------------------------------------------------------------------
   // Cell chain: fetched pairs shift in, then shift out to the updaters
   // in the same order (factor 0 first).
   // ---------------------------------------------------------------------
   assign chain_shift = rdv_ff || (state_ff == S_UPDATE);
   assign p_link[0]   = rdv_ff ? $signed(u_rdata_ff) : 32'sd0;
   assign q_link[0]   = rdv_ff ? $signed(i_rdata_ff) : 32'sd0;

   for (genvar c = 0; c < RANK; c++) begin : g_cell
      mfsgd_cell u_cell (
         .clock   (clock),
         .shift_i (chain_shift),
         .p_i     (p_link[c]),
         .q_i     (q_link[c]),
         .p_o     (p_link[c+1]),
         .q_o     (q_link[c+1])
      );
   end

   // user factor update uses the old item factor and vice versa
   mfsgd_upd u_upd_p (
      .clock   (clock),
      .reset   (reset),
      .tag_i   (upd_tag),
      .f_i     (p_link[RANK]),
      .g_i     (q_link[RANK]),
      .err_i   (err_ff),
      .alpha_i (alpha_ff),
      .beta_i  (beta_ff),
      .tag_o   (p_tag),
      .new_o   (p_new),
      .sat_o   (p_sat),
      .busy_o  (p_busy)
   );

   mfsgd_upd u_upd_q (
      .clock   (clock),
      .reset   (reset),
      .tag_i   (upd_tag),
      .f_i     (q_link[RANK]),
      .g_i     (p_link[RANK]),
      .err_i   (err_ff),
      .alpha_i (alpha_ff),
      .beta_i  (beta_ff),
      .tag_o   (q_tag),
      .new_o   (q_new),
      .sat_o   (q_sat),
      .busy_o  (q_busy)
   );

`ifndef NO_ASSERTIONS
   // one port per memory: never read and write in one cycle
   a_user_port: assert property (@(posedge clock) disable iff (reset)
      !(u_we && u_re)) else $error("user memory read and write together");
   a_item_port: assert property (@(posedge clock) disable iff (reset)
      !(i_we && i_re)) else $error("item memory read and write together");
   // both updaters run in lock step
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      p_tag == q_tag) else $error("update units out of step");
   // error is formed only after the dot product has drained
   a_mac_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ERR |-> !rdv_ff && !prod_v_ff) else $error("MAC not drained");
   // write-back finished before the response is formed
   a_wb_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> !p_busy && !q_busy) else $error("write-back pending");
`endif

endmodule

FILE: sim/tb_matrix_factorization_sgd_update_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_factorization_sgd_update_core : self-checking bench for the core
// Directed and random transactions. A predictor holds its own copy of both
// factor matrices and of alpha and beta, and each response is checked against it.
// ----------------------------------------------------------------------------
module tb_matrix_factorization_sgd_update_core;
   import mfsgd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned DRAIN_WAIT  = 60;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_index;
   logic [15:0] csr_wr_data;

   matrix_factorization_sgd_update_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // predictor state
   logic signed [31:0] user_mem [0:UDEPTH-1];
   logic signed [31:0] item_mem [0:IDEPTH-1];
   logic [15:0]        alpha_q;
   logic [15:0]        beta_q;

   rsp_type     expected_rsp[$];
   int unsigned errors;
   int unsigned cycles;
   int unsigned sent_count;
   int unsigned train_count;
   int unsigned sat_count;
   int unsigned stall_hold;   // long receiver hold-off, in cycles
   bit          stall_enable;

   // users / items whose whole row is written, so training on them is legal
   int unsigned ready_users[$];
   int unsigned ready_items[$];

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("matrix_factorization_sgd_update_core verification failed");
         $finish;
      end
   end

   // floor(x / 2^s)
   function automatic longint fshift(longint x, int s);
      return x >>> s;
   endfunction

   function automatic logic signed [31:0] clip(longint x, inout bit flag);
      if (x > longint'(S32_MAX)) begin
         flag = 1'b1;
         return S32_MAX;
      end
      if (x < longint'(S32_MIN)) begin
         flag = 1'b1;
         return S32_MIN;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] sgd_factor(logic signed [31:0] f,
         logic signed [31:0] g, logic signed [31:0] e, inout bit flag);
      longint grad, regp, d, hi, lo, stp;
      grad = 2 * fshift(longint'(e) * longint'(g), FRAC);
      regp = fshift(longint'(beta_q) * longint'(f), 16);
      d    = grad - regp;
      hi   = fshift(d, 16);
      lo   = d - (hi <<< 16);
      stp  = hi * longint'(alpha_q) + fshift(lo * longint'(alpha_q), 16);
      return clip(longint'(f) + stp, flag);
   endfunction

   function automatic rsp_type predict(req_type r);
      rsp_type o;
      bit sat;
      longint acc;
      logic signed [31:0] p, q;
      int unsigned ub, ib;
      o = '0;
      sat = 1'b0;
      ub = r.user_index * RANK;
      ib = r.item_index * RANK;
      case (r.opcode)
         OP_WR_USER: user_mem[ub + r.factor_index] = r.write_value;
         OP_WR_ITEM: item_mem[ib + r.factor_index] = r.write_value;
         OP_RD_USER: o.read_value = user_mem[ub + r.factor_index];
         OP_RD_ITEM: o.read_value = item_mem[ib + r.factor_index];
         OP_TRAIN: begin
            if (r.rating == 0) begin
               o.update_skipped = 1'b1;
            end else begin
               acc = 0;
               for (int k = 0; k < RANK; k++)
                  acc += fshift(longint'(user_mem[ub + k]) * longint'(item_mem[ib + k]), FRAC);
               o.prediction_error = clip((longint'(r.rating) <<< FRAC) - acc, sat);
               for (int k = 0; k < RANK; k++) begin
                  p = user_mem[ub + k];
                  q = item_mem[ib + k];
                  user_mem[ub + k] = sgd_factor(p, q, o.prediction_error, sat);
                  item_mem[ib + k] = sgd_factor(q, p, o.prediction_error, sat);
               end
               train_count++;
               if (sat) sat_count++;
            end
         end
         default: ;
      endcase
      o.saturated = sat;
      return o;
   endfunction

   // response checker: sample at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value exp %h got %h", want.read_value, rsp_data.read_value);
               errors++;
            end
            if (rsp_data.prediction_error !== want.prediction_error) begin
               $error("prediction_error exp %h got %h",
                      want.prediction_error, rsp_data.prediction_error);
               errors++;
            end
            if (rsp_data.update_skipped !== want.update_skipped) begin
               $error("update_skipped exp %b got %b",
                      want.update_skipped, rsp_data.update_skipped);
               errors++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated exp %b got %b", want.saturated, rsp_data.saturated);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, changed at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_hold != 0) begin
         rsp_ready  <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else if (!stall_enable) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // one transaction: drive at the falling edge, hold until accepted
   task automatic send_req(req_type r);
      req_data  = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(predict(r));
      sent_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // burst gaps: occasional idle cycles between transactions
   task automatic sender_gap();
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 8)) @(negedge clock);
   endtask

   task automatic wait_idle();
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] v);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = v;
      if (idx == CSR_ALPHA) alpha_q = v;
      else beta_q = v;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic req_type make_req(int unsigned op, int unsigned u, int unsigned i,
         int unsigned f, logic [31:0] v, int unsigned rt);
      req_type r;
      r.opcode = 3'(op);
      r.user_index = 10'(u);
      r.item_index = 10'(i);
      r.factor_index = 4'(f);
      r.write_value = v;
      r.rating = 8'(rt);
      return r;
   endfunction

   // small factors keep training mostly unsaturated; a few are wide
   function automatic logic [31:0] rand_factor();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $signed($urandom_range(0, 131071)) - 65536;
      endcase
   endfunction

   task automatic load_row(bit is_user, int unsigned idx);
      for (int k = 0; k < RANK; k++) begin
         send_req(make_req(is_user ? OP_WR_USER : OP_WR_ITEM, idx, idx, k,
                           rand_factor(), $urandom()));
         sender_gap();
      end
      if (is_user) ready_users.push_back(idx);
      else ready_items.push_back(idx);
   endtask

   // directed: extremes of every field, every opcode, zero rating, unused opcodes
   task automatic test_directed();
      send_req(make_req(OP_WR_USER, 0, 1023, 0, 32'h7FFF_FFFF, 8'hFF));
      send_req(make_req(OP_WR_ITEM, 1023, 1023, 15, 32'h8000_0000, 8'h00));
      send_req(make_req(OP_RD_USER, 0, 0, 0, 32'h0, 8'h0));
      send_req(make_req(OP_RD_ITEM, 0, 1023, 15, 32'hFFFF_FFFF, 8'hFF));
      load_row(1'b1, 1023);
      load_row(1'b0, 0);
      load_row(1'b0, 1023);
      send_req(make_req(OP_TRAIN, 1023, 0, 15, 32'hFFFF_FFFF, 8'd0));    // zero rating
      send_req(make_req(OP_TRAIN, 1023, 0, 0, 32'h0, 8'd255));
      send_req(make_req(OP_TRAIN, 1023, 1023, 0, 32'h0, 8'd1));
      for (int op = 5; op < 8; op++)
         send_req(make_req(op, $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
      // saturating train: huge factors
      for (int k = 0; k < RANK; k++) begin
         send_req(make_req(OP_WR_USER, 5, 0, k, 32'h7FFF_FFFF, 8'd0));
         send_req(make_req(OP_WR_ITEM, 0, 5, k, 32'h8000_0000, 8'd0));
      end
      ready_users.push_back(5);
      ready_items.push_back(5);
      send_req(make_req(OP_TRAIN, 5, 5, 0, 32'h0, 8'd255));
      send_req(make_req(OP_RD_USER, 5, 5, 3, 32'h0, 8'd0));
      wait_idle();
   endtask

   task automatic test_random(int unsigned count);
      req_type r;
      int unsigned u, i, n;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0, 1: begin   // fresh row
               if ($urandom_range(0, 1)) load_row(1'b1, $urandom_range(0, 1023));
               else load_row(1'b0, $urandom_range(0, 1023));
               n += RANK;
            end
            2, 3: begin   // single write
               r = make_req($urandom_range(0, 1), $urandom(), $urandom(), $urandom(),
                            rand_factor(), $urandom());
               send_req(r);
               n++;
            end
            4, 5: begin   // read of a written entry
               u = ready_users[$urandom_range(0, ready_users.size() - 1)];
               i = ready_items[$urandom_range(0, ready_items.size() - 1)];
               r = make_req($urandom_range(0, 1) ? OP_RD_USER : OP_RD_ITEM,
                            u, i, $urandom(), $urandom(), $urandom());
               send_req(r);
               n++;
            end
            6: begin      // noise: unused opcode
               send_req(make_req($urandom_range(5, 7), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom()));
            end
            default: begin
               u = ready_users[$urandom_range(0, ready_users.size() - 1)];
               i = ready_items[$urandom_range(0, ready_items.size() - 1)];
               r = make_req(OP_TRAIN, u, i, $urandom(), $urandom(),
                            ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom()));
               send_req(r);
               n++;
            end
         endcase
         sender_gap();
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      @(negedge clock);
      stall_hold = 300;
      test_random(20);
      wait_idle();
   endtask

   task automatic test_config_sweep();
      logic [15:0] a_set[4] = '{16'd0, 16'hFFFF, 16'd4000, 16'd655};
      logic [15:0] b_set[4] = '{16'hFFFF, 16'd0, 16'd20000, 16'd1311};
      for (int s = 0; s < 4; s++) begin
         write_csr(CSR_ALPHA, a_set[s]);
         write_csr(CSR_BETA, b_set[s]);
         test_random(180);
         wait_idle();   // sender pauses until everything has drained
      end
   endtask

   initial begin
      errors = 0; cycles = 0; sent_count = 0; train_count = 0; sat_count = 0;
      stall_hold = 0; stall_enable = 1'b0;
      alpha_q = ALPHA_RESET;
      beta_q  = BETA_RESET;
      for (int n = 0; n < UDEPTH; n++) user_mem[n] = '0;
      for (int n = 0; n < IDEPTH; n++) item_mem[n] = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_ALPHA;
      csr_wr_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      stall_enable = 1'b1;
      test_backpressure();
      test_config_sweep();
      test_random(80);
      wait_idle();

      $display("sent %0d transactions, %0d updating trains, %0d saturated",
               sent_count, train_count, sat_count);
      $display("covered loads, reads, trains, skips, unused opcodes and 4 csr settings");
      if (errors == 0) begin
         $display("matrix_factorization_sgd_update_core verification clean");
      end else begin
         $display("matrix_factorization_sgd_update_core verification failed");
      end
      $finish;
   end
endmodule

FILE: filelist.f
hw/rtl/mfsgd_pkg.sv
hw/rtl/mfsgd_cell.sv
hw/rtl/mfsgd_upd.sv
hw/rtl/matrix_factorization_sgd_update_core.sv
sim/tb_matrix_factorization_sgd_update_core.sv
